### design/tmr_pkg.sv
// Package: shared constants and the gamma curve for the transmission map refiner.
package tmr_pkg;

  localparam int PIXEL_BITS = 16;
  localparam int WIDTH_CFG_BITS = 11;
  localparam int HEIGHT_CFG_BITS = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int DIM_BITS = 13;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_FLUSH = 1'b1
  } req_kind_t;

  function automatic int gamma_entry(input int i, input int index_bits, input int sample_bits);
    real x;
    real y;
    int  v;
    int  cap;
    x = real'(i) * (2.0 ** (-(index_bits - 1)));
    y = 0.1 * (x ** 1.3) * (2.0 ** (sample_bits - 1));
    v = int'($floor(y + 0.5));
    cap = (1 << sample_bits) - 1;
    return (v > cap) ? cap : v;
  endfunction

endpackage

### design/tmr_if.sv
// Interfaces: pixel request channel and refined result channel.
interface tmr_in_if import tmr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [PIXEL_BITS-1:0] pixel_value;
  modport source (output valid, req_type, pixel_value, input ready);
  modport sink (input valid, req_type, pixel_value, output ready);
endinterface

interface tmr_out_if import tmr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] refined_value;
  logic                  frame_last;
  modport source (output valid, refined_value, frame_last, input ready);
  modport sink (input valid, refined_value, frame_last, output ready);
endinterface

### design/transmission_map_refine_3x3_median_top.sv
// Top level: gamma lookup, line-buffer memory, 3x3 median and clamped residual.
// Throughput: one request per cycle while the output is not stalled; one line memory port pair sets the pace.
// A result passes the s1, s2 and s3 registers into the output register after the
// request that completes it is accepted; a pixel's result needs frame_width+1 later requests.
// Reset clears counters, window and pipeline valids; the line memory is not
// cleared and needs no clearing pass, so requests are taken right after reset.
module transmission_map_refine_3x3_median_top import tmr_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int SAMPLE_BITS = 16,
  parameter int GAMMA_INDEX_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  tmr_in_if.sink                   in_ch,
  tmr_out_if.source                out_ch,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);
  localparam int SB = SAMPLE_BITS;
  localparam int GIB = GAMMA_INDEX_BITS;
  localparam int ROM_DEPTH = 1 << GIB;
  localparam int AB = $clog2(MAX_WIDTH);
  localparam int CB = $clog2(MAX_WIDTH + 1);
  localparam int IB = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);
  localparam int SH_R = (SB >= GIB) ? SB - GIB : 0;
  localparam int SH_L = (GIB > SB) ? GIB - SB : 0;
  localparam int W_RST = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int LIMIT_RST = W_RST * 480 + W_RST + 1;
  localparam int SW = DIM_BITS + 2;

  // configuration
  logic [WIDTH_CFG_BITS-1:0]  frame_width;
  logic [HEIGHT_CFG_BITS-1:0] frame_height;
  logic                       cfg_we;
  logic [DIM_BITS-1:0]        weff;
  logic [DIM_BITS-1:0]        heff;
  logic [IB-1:0]              limit_q;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= WIDTH_CFG_BITS'(640);
      frame_height <= HEIGHT_CFG_BITS'(480);
      limit_q <= IB'(LIMIT_RST);
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(paddr[2]))
          REG_FRAME_WIDTH:  frame_width <= pwdata[WIDTH_CFG_BITS-1:0];
          REG_FRAME_HEIGHT: frame_height <= pwdata[HEIGHT_CFG_BITS-1:0];
          default: ;
        endcase
      end
      limit_q <= IB'(weff) * IB'(heff) + IB'(weff) + IB'(1);
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[2]))
      REG_FRAME_WIDTH:  prdata = APB_DATA_BITS'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_BITS'(frame_height);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    weff = DIM_BITS'(frame_width);
    if (weff == '0) weff = DIM_BITS'(1);
    if (weff > DIM_BITS'(MAX_WIDTH)) weff = DIM_BITS'(MAX_WIDTH);
    heff = frame_height;
    if (heff == '0) heff = DIM_BITS'(1);
    if (heff > DIM_BITS'(MAX_HEIGHT)) heff = DIM_BITS'(MAX_HEIGHT);
  end

  // gamma table
  logic [SB-1:0] gamma_lut [ROM_DEPTH];
  for (genvar gi = 0; gi < ROM_DEPTH; gi++) begin : g_lut
    assign gamma_lut[gi] = SB'(gamma_entry(gi, GIB, SB));
  end

  // pipeline control
  logic en;
  logic accept;
  logic s1_v, s2_v, s3_v;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign accept = in_ch.valid && en;

  // stage 0: position counters and memory read
  logic [CB-1:0]       col_q, col_next, cin, col_inc;
  logic [DIM_BITS-1:0] row_q, row_next;
  logic [IB-1:0]       items_q, items_next, items_inc;
  logic [SB-1:0]       sample0;
  logic [GIB-1:0]      idx0;

  assign sample0 = (in_ch.req_type == REQ_FLUSH) ? '0 : SB'(in_ch.pixel_value);
  assign idx0 = GIB'(((SB + GIB)'(sample0) << SH_L) >> SH_R);

  always_comb begin
    cin = (col_q < CB'(MAX_WIDTH)) ? col_q : '0;
    col_inc = cin + CB'(1);
    col_next = col_inc;
    row_next = row_q;
    if (DIM_BITS'(col_inc) >= weff) begin
      col_next = '0;
      row_next = row_q + DIM_BITS'(1);
    end
    items_inc = items_q + IB'(1);
    items_next = items_inc;
    if (items_inc >= limit_q) begin
      items_next = '0;
      col_next = '0;
      row_next = '0;
    end
  end

  logic [3*SB-1:0] ram_wdata, ram_rdata;
  logic            ram_we;
  logic [AB-1:0]   s1_addr;

  tmr_ram #(.WIDTH(3 * SB), .DEPTH(MAX_WIDTH)) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (cin[AB-1:0]),
    .rdata (ram_rdata)
  );

  logic [CB-1:0]       s1_cin;
  logic [DIM_BITS-1:0] s1_row;
  logic [IB-1:0]       s1_items;
  logic [SB-1:0]       s1_sample;
  logic [SB-1:0]       s1_g;
  logic                fwd_hit;
  logic [3*SB-1:0]     fwd_data;

  assign s1_addr = s1_cin[AB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      col_q <= '0;
      row_q <= '0;
      items_q <= '0;
      s1_v <= 1'b0;
      fwd_hit <= 1'b0;
    end else if (en) begin
      s1_v <= accept;
      fwd_hit <= accept && s1_v && (s1_cin == cin);
      if (accept) begin
        col_q <= col_next;
        row_q <= row_next;
        items_q <= items_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_data <= ram_wdata;
      if (accept) begin
        s1_cin <= cin;
        s1_row <= row_q;
        s1_items <= items_q;
        s1_sample <= sample0;
        s1_g <= (in_ch.req_type == REQ_FLUSH) ? '0 : gamma_lut[idx0];
      end
    end
  end

  // stage 1: window update, write-back, border masking
  logic [3*SB-1:0]        rd;
  logic [SB-1:0]          up, mid, g;
  logic [SB-1:0]          win_q [9];
  logic [SB-1:0]          win [9];
  logic [SB-1:0]          raw_lag_q;
  logic signed [SW-1:0]   c, r;
  logic                   produce, last1;
  logic [8:0]             ok;

  assign rd = fwd_hit ? fwd_data : ram_rdata;
  assign up = rd[3*SB-1:2*SB];
  assign mid = rd[2*SB-1:SB];
  assign g = s1_g;
  assign ram_wdata = {mid, g, s1_sample};
  assign ram_we = en && s1_v;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      win[k] = win_q[k+3];
    end
    win[6] = up;
    win[7] = mid;
    win[8] = g;
    if (s1_cin != '0) begin
      c = SW'(s1_cin) - SW'(1);
      r = SW'(s1_row) - SW'(1);
    end else begin
      c = SW'(weff) - SW'(1);
      r = SW'(s1_row) - SW'(2);
    end
    produce = (s1_items >= IB'(weff) + IB'(1)) && (r >= 0) && (r < SW'(heff));
    last1 = (r == SW'(heff) - SW'(1)) && (c == SW'(weff) - SW'(1));
    for (int k = 0; k < 9; k++) begin
      ok[k] = 1'b1;
      if (k / 3 == 0 && c <= 0) ok[k] = 1'b0;
      if (k / 3 == 2 && c + SW'(1) >= SW'(weff)) ok[k] = 1'b0;
      if (k % 3 == 0 && r <= 0) ok[k] = 1'b0;
      if (k % 3 == 2 && r + SW'(1) >= SW'(heff)) ok[k] = 1'b0;
    end
  end

  logic [SB-1:0] s2_v9 [9];
  logic [SB-1:0] s2_raw;
  logic          s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
      raw_lag_q <= '0;
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v && produce;
      if (s1_v) begin
        for (int k = 0; k < 9; k++) begin
          win_q[k] <= win[k];
        end
        raw_lag_q <= rd[SB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_v) begin
      for (int k = 0; k < 9; k++) begin
        s2_v9[k] <= ok[k] ? win[k] : '0;
      end
      s2_raw <= raw_lag_q;
      s2_last <= last1;
    end
  end

  // stage 2: sort each column
  function automatic logic [SB-1:0] min2(input logic [SB-1:0] a, input logic [SB-1:0] b);
    return (a < b) ? a : b;
  endfunction
  function automatic logic [SB-1:0] max2(input logic [SB-1:0] a, input logic [SB-1:0] b);
    return (a < b) ? b : a;
  endfunction
  function automatic logic [SB-1:0] med3(input logic [SB-1:0] a, input logic [SB-1:0] b,
                                         input logic [SB-1:0] d);
    return max2(min2(a, b), min2(max2(a, b), d));
  endfunction

  logic [SB-1:0] s3_lo [3];
  logic [SB-1:0] s3_md [3];
  logic [SB-1:0] s3_hi [3];
  logic [SB-1:0] s3_raw;
  logic          s3_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s3_lo[k] <= min2(min2(s2_v9[3*k], s2_v9[3*k+1]), s2_v9[3*k+2]);
        s3_md[k] <= med3(s2_v9[3*k], s2_v9[3*k+1], s2_v9[3*k+2]);
        s3_hi[k] <= max2(max2(s2_v9[3*k], s2_v9[3*k+1]), s2_v9[3*k+2]);
      end
      s3_raw <= s2_raw;
      s3_last <= s2_last;
    end
  end

  // stage 3: median and residual into the output register
  logic [SB-1:0]        med;
  logic signed [SB+1:0] d;
  logic [SB-1:0]        res;

  always_comb begin
    med = med3(max2(max2(s3_lo[0], s3_lo[1]), s3_lo[2]),
               med3(s3_md[0], s3_md[1], s3_md[2]),
               min2(min2(s3_hi[0], s3_hi[1]), s3_hi[2]));
    d = $signed({2'b00, s3_raw}) - $signed({2'b00, med});
    if (d > $signed((SB + 2)'(1) <<< (SB - 1))) res = SB'(1) << (SB - 1);
    else if (d > 0) res = SB'(d);
    else if (d < 0) res = '0;
    else res = s3_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.refined_value <= PIXEL_BITS'(res);
      out_ch.frame_last <= s3_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_reset_clears: assert property (@(posedge clk) rst |=> !s1_v && !s2_v && !s3_v && !out_ch.valid)
    else $error("pipeline valid survived reset");
  a_fwd_needs_item: assert property (@(posedge clk) disable iff (rst) fwd_hit |-> s1_v)
    else $error("forwarding flagged with no item in stage 1");
  a_s2_source: assert property (@(posedge clk) disable iff (rst) $rose(s2_v) |-> $past(s1_v))
    else $error("median stage filled without a stage 1 item");
  a_width_nonzero: assert property (@(posedge clk) disable iff (rst) weff != '0)
    else $error("effective width is zero");
`endif
endmodule

### design/tmr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tmr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
